// ----- rtl/pointer_piecewise_accel_carry_unit_defines.svh -----
// Assertion macros for the pointer acceleration block.
// Used by the port checker; expects clk and rst in scope.
`ifndef POINTER_PIECEWISE_ACCEL_CARRY_UNIT_DEFINES_SVH
`define POINTER_PIECEWISE_ACCEL_CARRY_UNIT_DEFINES_SVH

// same-cycle implication
`define PPAC_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define PPAC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- rtl/ppac_pkg.sv -----
// Shared types and constants for the pointer acceleration block.
// No dependencies.
package ppac_pkg;

  localparam int SEGMENTS   = 4;
  localparam int SEG_W      = 2;
  localparam int SEG_CNT_W  = 3;
  localparam int TAB_W      = 64;
  localparam int FIELD_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 24;
  localparam int SPEED_W    = 17;
  localparam int DIVS_W     = SPEED_W;
  localparam int DIVD_W     = FIELD_W + SPEED_W;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int DIV_CNT_W  = 6;
  localparam int GAIN_W     = 34;
  localparam int PROD_W     = IN_W + GAIN_W;
  localparam int SUM_W      = PROD_W - 3;
  localparam int FRAC_W     = 16;
  localparam int CARRY_W    = FRAC_W + 1;

  localparam logic [GAIN_W-1:0]    GAIN_ONE        = GAIN_W'(65536);
  localparam logic [TAB_W-1:0]     BP_RESET        = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [TAB_W-1:0]     SLOPE_RESET     = 64'h1000_1000_1000_1000;
  localparam logic [TAB_W-1:0]     OFFSET_RESET    = 64'h0;
  localparam logic [SEG_CNT_W-1:0] SEG_COUNT_RESET = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BREAKPOINT = 3'd0,
    REG_SLOPE      = 3'd1,
    REG_OFFSET     = 3'd2,
    REG_SEG_COUNT  = 3'd3,
    REG_CARRY_MODE = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_SPEED,
    ST_SEG,
    ST_LOAD,
    ST_DIV,
    ST_GAIN,
    ST_MUL,
    ST_SHIFT,
    ST_ACC,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [IN_W-1:0] in_dx;
    logic signed [IN_W-1:0] in_dy;
    logic                   hold;
  } motion_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_dx;
    logic signed [OUT_W-1:0] out_dy;
    logic [SEG_W-1:0]        segment_used;
  } result_t;

endpackage

// ----- rtl/pointer_piecewise_accel_carry_unit.sv -----
// Channel   Handshake            Payload
// req       req_valid/req_ready  ppac_pkg::motion_t (in_dx, in_dy, hold)
// rsp       rsp_valid/rsp_ready  ppac_pkg::result_t (out_dx, out_dy, segment_used)
// cfg       cfg_we               cfg_index, cfg_data (write only)
//
// A new report is accepted only in ST_IDLE, once the last one is through; the
// 33-step radix-2 divider for offset over speed is skipped for a zero-motion report.
// One multiplier, shifter and adder are shared by the x and y axes in turn.
// rst is synchronous; it loads the curve registers with their defaults and
// clears the carries. A stalled rsp holds one result while the next report runs.
module pointer_piecewise_accel_carry_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  ppac_pkg::motion_t                req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output ppac_pkg::result_t                rsp,
  input  logic                             cfg_we,
  input  logic [ppac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppac_pkg::TAB_W-1:0]       cfg_data
);

  localparam int FW = ppac_pkg::FIELD_W;

  ppac_pkg::state_t state, state_next;

  logic [ppac_pkg::TAB_W-1:0]      bp_tab, slope_tab, offset_tab;
  logic [ppac_pkg::SEG_CNT_W-1:0]  seg_count;
  logic                            carry_mode;

  logic signed [ppac_pkg::IN_W-1:0]     dx, dy;
  logic                                 hold;
  logic [ppac_pkg::IN_W-1:0]            ax, ay;
  logic [ppac_pkg::SPEED_W-1:0]         v5;
  logic [ppac_pkg::SEG_W-1:0]           seg;
  logic                                 off_neg;
  logic signed [ppac_pkg::GAIN_W-1:0]   gain;
  logic signed [ppac_pkg::PROD_W-1:0]   prod;
  logic signed [ppac_pkg::SUM_W-1:0]    acc;
  logic                                 axis;
  logic signed [ppac_pkg::OUT_W-1:0]    res_x, res_y;
  logic signed [ppac_pkg::CARRY_W-1:0]  carry_x, carry_y;

  logic                                 div_start, div_busy, load_rsp;
  logic [ppac_pkg::DIVD_W-1:0]          dividend, quotient;
  logic [FW-1:0]                        off_f, off_mag, slope_f;
  logic [ppac_pkg::SEG_CNT_W-1:0]       count;
  logic [ppac_pkg::SEG_W-1:0]           seg_sel;
  logic [ppac_pkg::IN_W-1:0]            big, small_c;
  logic signed [ppac_pkg::IN_W-1:0]     d_sel;
  logic signed [ppac_pkg::PROD_W-1:0]   mul_p, biased;
  logic signed [ppac_pkg::PROD_W-1:0]   sh4, sh16;
  logic signed [ppac_pkg::CARRY_W-1:0]  carry_sel, carry_new;
  logic signed [ppac_pkg::OUT_W-1:0]    axis_res;
  logic [ppac_pkg::GAIN_W-1:0]          gain_sum;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      bp_tab     <= ppac_pkg::BP_RESET;
      slope_tab  <= ppac_pkg::SLOPE_RESET;
      offset_tab <= ppac_pkg::OFFSET_RESET;
      seg_count  <= ppac_pkg::SEG_COUNT_RESET;
      carry_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (ppac_pkg::cfg_reg_t'(cfg_index))
        ppac_pkg::REG_BREAKPOINT: bp_tab     <= cfg_data;
        ppac_pkg::REG_SLOPE:      slope_tab  <= cfg_data;
        ppac_pkg::REG_OFFSET:     offset_tab <= cfg_data;
        ppac_pkg::REG_SEG_COUNT:  seg_count  <= cfg_data[ppac_pkg::SEG_CNT_W-1:0];
        ppac_pkg::REG_CARRY_MODE: carry_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // segment search
  always_comb begin
    if (seg_count == '0) begin
      count = ppac_pkg::SEG_CNT_W'(1);
    end else if (seg_count > ppac_pkg::SEG_CNT_W'(ppac_pkg::SEGMENTS)) begin
      count = ppac_pkg::SEG_CNT_W'(ppac_pkg::SEGMENTS);
    end else begin
      count = seg_count;
    end
    seg_sel = ppac_pkg::SEG_W'(count - 1'b1);
    for (int i = ppac_pkg::SEGMENTS - 1; i >= 0; i--) begin
      if ((ppac_pkg::SEG_CNT_W'(i) < count) && (v5 <= {bp_tab[FW*i +: FW], 1'b0})) begin
        seg_sel = ppac_pkg::SEG_W'(i);
      end
    end
  end

  assign big       = (ax > ay) ? ax : ay;
  assign small_c   = (ax > ay) ? ay : ax;
  assign off_f     = offset_tab[FW*seg +: FW];
  assign off_mag   = off_f[FW-1] ? FW'(-off_f) : off_f;
  assign dividend  = {off_mag, {ppac_pkg::SPEED_W{1'b0}}};
  assign slope_f   = slope_tab[FW*seg +: FW];
  assign gain_sum  = ppac_pkg::GAIN_W'({slope_f, 4'b0000})
                   + {off_neg, quotient ^ {ppac_pkg::DIVD_W{off_neg}}}
                   + ppac_pkg::GAIN_W'(off_neg);
  assign d_sel     = axis ? dy : dx;
  assign mul_p     = d_sel * gain;
  assign biased    = prod + (prod[ppac_pkg::PROD_W-1]
                             ? (carry_mode ? ppac_pkg::PROD_W'(15) : ppac_pkg::PROD_W'(65535))
                             : '0);
  assign sh4       = biased >>> 4;
  assign sh16      = biased >>> 16;
  assign carry_sel = axis ? carry_y : carry_x;

  ppac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (v5),
    .busy     (div_busy),
    .quotient (quotient)
  );

  ppac_axis u_axis (
    .acc        (acc),
    .touch_mode (carry_mode),
    .res        (axis_res),
    .carry_next (carry_new)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    div_start  = 1'b0;
    load_rsp   = 1'b0;
    unique case (state)
      ppac_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) state_next = ppac_pkg::ST_ABS;
      end
      ppac_pkg::ST_ABS:   state_next = ppac_pkg::ST_SPEED;
      ppac_pkg::ST_SPEED: state_next = ppac_pkg::ST_SEG;
      ppac_pkg::ST_SEG:   state_next = ppac_pkg::ST_LOAD;
      ppac_pkg::ST_LOAD: begin
        if (v5 != '0) begin
          div_start  = 1'b1;
          state_next = ppac_pkg::ST_DIV;
        end else begin
          state_next = ppac_pkg::ST_GAIN;
        end
      end
      ppac_pkg::ST_DIV: begin
        if (!div_busy) state_next = ppac_pkg::ST_GAIN;
      end
      ppac_pkg::ST_GAIN:  state_next = ppac_pkg::ST_MUL;
      ppac_pkg::ST_MUL:   state_next = ppac_pkg::ST_SHIFT;
      ppac_pkg::ST_SHIFT: state_next = ppac_pkg::ST_ACC;
      ppac_pkg::ST_ACC:   state_next = ppac_pkg::ST_FIN;
      ppac_pkg::ST_FIN: begin
        state_next = axis ? ppac_pkg::ST_OUT : ppac_pkg::ST_MUL;
      end
      ppac_pkg::ST_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = ppac_pkg::ST_IDLE;
        end
      end
      default: state_next = ppac_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ppac_pkg::ST_IDLE: begin
        if (req_valid) begin
          dx   <= req.in_dx;
          dy   <= req.in_dy;
          hold <= req.hold;
        end
      end
      ppac_pkg::ST_ABS: begin
        ax <= dx[ppac_pkg::IN_W-1] ? ppac_pkg::IN_W'(-dx) : dx;
        ay <= dy[ppac_pkg::IN_W-1] ? ppac_pkg::IN_W'(-dy) : dy;
      end
      ppac_pkg::ST_SPEED: v5 <= {big, 1'b0} + {1'b0, small_c};
      ppac_pkg::ST_SEG:   seg <= seg_sel;
      ppac_pkg::ST_LOAD:  off_neg <= off_f[FW-1];
      ppac_pkg::ST_GAIN: begin
        gain <= (v5 == '0) ? ppac_pkg::GAIN_ONE : gain_sum;
        axis <= 1'b0;
      end
      ppac_pkg::ST_MUL:   prod <= mul_p;
      ppac_pkg::ST_SHIFT: begin
        acc <= carry_mode ? sh4[ppac_pkg::SUM_W-1:0] : sh16[ppac_pkg::SUM_W-1:0];
      end
      ppac_pkg::ST_ACC: begin
        if (carry_mode) acc <= acc + ppac_pkg::SUM_W'(carry_sel);
      end
      ppac_pkg::ST_FIN: begin
        axis <= 1'b1;
        if (axis) begin
          res_y <= hold ? '0 : axis_res;
        end else begin
          res_x <= hold ? '0 : axis_res;
        end
      end
      default: ;
    endcase
  end

  // kept fractions
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_x <= '0;
      carry_y <= '0;
    end else if (state == ppac_pkg::ST_FIN && carry_mode && !hold) begin
      if (axis) begin
        carry_y <= carry_new;
      end else begin
        carry_x <= carry_new;
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.out_dx       <= res_x;
      rsp.out_dy       <= res_y;
      rsp.segment_used <= seg;
    end
  end

endmodule

// ----- rtl/ppac_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ppac_pkg.
module ppac_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ppac_pkg::DIVD_W-1:0]    dividend,
  input  logic [ppac_pkg::DIVS_W-1:0]    divisor,
  output logic                           busy,
  output logic [ppac_pkg::DIVD_W-1:0]    quotient
);

  logic [ppac_pkg::DIVS_W-1:0]      rem;
  logic [ppac_pkg::DIVD_W-1:0]      quo;
  logic [ppac_pkg::DIV_CNT_W-1:0]   cnt;
  logic [ppac_pkg::DIVS_W:0]        rem_sh;
  logic [ppac_pkg::DIVS_W:0]        diff;
  logic                             ge;

  assign rem_sh   = {rem, quo[ppac_pkg::DIVD_W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign diff     = rem_sh - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == ppac_pkg::DIV_CNT_W'(ppac_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[ppac_pkg::DIVS_W-1:0] : rem_sh[ppac_pkg::DIVS_W-1:0];
      quo <= {quo[ppac_pkg::DIVD_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/ppac_axis.sv -----
// Per-axis output stage: whole/fraction split with carry in touch mode, and saturation.
// Depends on ppac_pkg.
module ppac_axis (
  input  logic signed [ppac_pkg::SUM_W-1:0]   acc,
  input  logic                                touch_mode,
  output logic signed [ppac_pkg::OUT_W-1:0]   res,
  output logic signed [ppac_pkg::CARRY_W-1:0] carry_next
);

  localparam int WHOLE_W = ppac_pkg::SUM_W - ppac_pkg::FRAC_W;

  logic signed [WHOLE_W-1:0]          whole;
  logic signed [ppac_pkg::SUM_W-1:0]  whole_q4;
  logic                               round_up;

  function automatic logic signed [ppac_pkg::OUT_W-1:0] sat_out(
    input logic signed [ppac_pkg::SUM_W-1:0] v
  );
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[ppac_pkg::SUM_W-1:ppac_pkg::OUT_W-1];
    hi_zeros = ~(|v[ppac_pkg::SUM_W-1:ppac_pkg::OUT_W-1]);
    if (hi_ones || hi_zeros) begin
      return v[ppac_pkg::OUT_W-1:0];
    end else if (v[ppac_pkg::SUM_W-1]) begin
      return {1'b1, {(ppac_pkg::OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ppac_pkg::OUT_W-1){1'b1}}};
    end
  endfunction

  // toward-zero split: negative sums with a fraction round the whole part up
  always_comb begin
    round_up   = acc[ppac_pkg::SUM_W-1] & (|acc[ppac_pkg::FRAC_W-1:0]);
    whole      = acc[ppac_pkg::SUM_W-1:ppac_pkg::FRAC_W] + WHOLE_W'(round_up);
    carry_next = {round_up, acc[ppac_pkg::FRAC_W-1:0]};
    whole_q4   = {{(ppac_pkg::SUM_W - WHOLE_W - 4){whole[WHOLE_W-1]}}, whole, 4'b0000};
    res        = touch_mode ? sat_out(whole_q4) : sat_out(acc);
  end

endmodule

// ----- rtl/ppac_checker.sv -----
// Port checker for pointer_piecewise_accel_carry_unit, bound to the top level.
// Depends on ppac_pkg and the assertion macro header.
`include "pointer_piecewise_accel_carry_unit_defines.svh"

module ppac_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input ppac_pkg::result_t rsp
);

  logic [1:0] outstanding;
  logic       req_beat, rsp_beat, rsp_stall;

  assign req_beat  = req_valid && req_ready;
  assign rsp_beat  = rsp_valid && rsp_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (req_beat && !rsp_beat) begin
      outstanding <= outstanding + 1'b1;
    end else if (rsp_beat && !req_beat) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  `PPAC_ASSERT_NEXT(a_rsp_stable, rsp_stall, rsp_valid && $stable(rsp), "rsp moved in stall")
  `PPAC_ASSERT_NEXT(a_one_at_a_time, req_beat, !req_ready, "req accepted twice in a row")
  `PPAC_ASSERT_NOW(a_no_phantom, rsp_valid, outstanding != 2'd0, "rsp beat without a report")
  `PPAC_ASSERT_NOW(a_depth, req_beat, outstanding < 2'd2 || rsp_beat, "too many reports in flight")

endmodule

bind pointer_piecewise_accel_carry_unit ppac_checker u_ppac_checker (.*);

// ----- tb/sv/tb_pointer_piecewise_accel_carry_unit.sv -----
// Testbench for pointer_piecewise_accel_carry_unit: directed and random motion reports,
// checked beat by beat against an in-bench predictor of the acceleration curve.
// Depends on ppac_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_pointer_piecewise_accel_carry_unit;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam longint Q4_MAX      = 64'sd8388607;
  localparam longint Q4_MIN      = -64'sd8388608;

  logic                           clk;
  logic                           rst;
  logic                           req_valid;
  logic                           req_ready;
  ppac_pkg::motion_t              req;
  logic                           rsp_valid;
  logic                           rsp_ready;
  ppac_pkg::result_t              rsp;
  logic                           cfg_we;
  logic [ppac_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ppac_pkg::TAB_W-1:0]     cfg_data;

  // curve registers and carries as the block should hold them
  logic [ppac_pkg::TAB_W-1:0]            bp_tab;
  logic [ppac_pkg::TAB_W-1:0]            slope_tab;
  logic [ppac_pkg::TAB_W-1:0]            off_tab;
  logic [ppac_pkg::SEG_CNT_W-1:0]        seg_count;
  logic                                  touch_mode;
  logic signed [ppac_pkg::CARRY_W-1:0]   carry_q [2];

  ppac_pkg::result_t pending_results [$];
  ppac_pkg::result_t want_rsp;
  int      mismatch_cnt;
  int      cycle_cnt;
  int      burst_left;
  bit      sender_gaps;
  bit      rcv_stall_en;
  bit      rcv_on;
  int      rcv_run;
  int      rsp_holdoff;

  pointer_piecewise_accel_carry_unit i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint trunc_shift(longint v, int n);
    if (v < 0) return -((-v) >>> n);
    return v >> n;
  endfunction

  function automatic logic signed [ppac_pkg::OUT_W-1:0] clamp_q4(longint v);
    if (v > Q4_MAX) return ppac_pkg::OUT_W'(Q4_MAX);
    if (v < Q4_MIN) return ppac_pkg::OUT_W'(Q4_MIN);
    return ppac_pkg::OUT_W'(v);
  endfunction

  // scaled is Q.20; the carry keeps the signed Q.16 fraction
  function automatic logic signed [ppac_pkg::OUT_W-1:0] touch_axis(longint scaled, int axis);
    longint sum, whole;
    sum = trunc_shift(scaled, 4) + longint'(carry_q[axis]);
    whole = trunc_shift(sum, 16);
    carry_q[axis] = ppac_pkg::CARRY_W'(sum - whole * 65536);
    return clamp_q4(whole * 16);
  endfunction

  function automatic ppac_pkg::result_t accel_motion(ppac_pkg::motion_t m);
    longint  dx, dy, ax, ay, big, lit, spd5, gain;
    int      cnt, seg;
    ppac_pkg::result_t r;
    dx = longint'($signed(m.in_dx));
    dy = longint'($signed(m.in_dy));
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    big = (ax > ay) ? ax : ay;
    lit = (ax > ay) ? ay : ax;
    spd5 = 2 * big + lit;
    cnt = int'(seg_count);
    if (cnt < 1) cnt = 1;
    if (cnt > ppac_pkg::SEGMENTS) cnt = ppac_pkg::SEGMENTS;
    seg = cnt - 1;
    for (int i = cnt - 1; i >= 0; i--) begin
      if (spd5 <= 2 * longint'(bp_tab[16*i +: 16])) seg = i;
    end
    if (spd5 == 0) begin
      gain = longint'(ppac_pkg::GAIN_ONE);
    end else begin
      gain = longint'(slope_tab[16*seg +: 16]) * 16
           + (longint'($signed(off_tab[16*seg +: 16])) * 131072) / spd5;
    end
    r.segment_used = ppac_pkg::SEG_W'(seg);
    r.out_dx = '0;
    r.out_dy = '0;
    if (!m.hold) begin
      if (touch_mode) begin
        r.out_dx = touch_axis(dx * gain, 0);
        r.out_dy = touch_axis(dy * gain, 1);
      end else begin
        r.out_dx = clamp_q4(trunc_shift(dx * gain, 16));
        r.out_dy = clamp_q4(trunc_shift(dy * gain, 16));
      end
    end
    return r;
  endfunction

  function automatic ppac_pkg::motion_t mk_motion(int dx, int dy, bit hold);
    ppac_pkg::motion_t m;
    m.in_dx = ppac_pkg::IN_W'(dx);
    m.in_dy = ppac_pkg::IN_W'(dy);
    m.hold = hold;
    return m;
  endfunction

  function automatic logic signed [ppac_pkg::IN_W-1:0] edge_value();
    case ($urandom_range(0, 4))
      0: return ppac_pkg::IN_W'(-32768);
      1: return ppac_pkg::IN_W'(32767);
      2: return ppac_pkg::IN_W'(-1);
      3: return ppac_pkg::IN_W'(1);
      default: return '0;
    endcase
  endfunction

  function automatic ppac_pkg::motion_t rand_motion();
    ppac_pkg::motion_t m;
    case ($urandom_range(0, 9))
      0, 1: begin
        m.in_dx = ppac_pkg::IN_W'($urandom);
        m.in_dy = ppac_pkg::IN_W'($urandom);
      end
      2: begin
        m.in_dx = edge_value();
        m.in_dy = edge_value();
      end
      default: begin
        m.in_dx = ppac_pkg::IN_W'(int'($urandom_range(0, 256)) - 128);
        m.in_dy = ppac_pkg::IN_W'(int'($urandom_range(0, 256)) - 128);
      end
    endcase
    m.hold = ($urandom_range(0, 7) == 0);
    return m;
  endfunction

  task automatic write_reg(ppac_pkg::cfg_reg_t idx, logic [ppac_pkg::TAB_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ppac_pkg::REG_BREAKPOINT: bp_tab = val;
      ppac_pkg::REG_SLOPE:      slope_tab = val;
      ppac_pkg::REG_OFFSET:     off_tab = val;
      ppac_pkg::REG_SEG_COUNT:  seg_count = val[ppac_pkg::SEG_CNT_W-1:0];
      ppac_pkg::REG_CARRY_MODE: touch_mode = val[0];
      default: ;
    endcase
  endtask

  // valid stays up across a burst; a gap drops it at the next falling edge
  task automatic send_motion(ppac_pkg::motion_t m);
    @(negedge clk);
    req <= m;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), accel_motion(m));
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        @(negedge clk);
        req_valid <= 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_default_curve();
    send_motion(mk_motion(0, 0, 1'b0));
    send_motion(mk_motion(32767, -32768, 1'b0));
    send_motion(mk_motion(-32768, 32767, 1'b1));
    send_motion(mk_motion(-1, 1, 1'b0));
    drain_results();
  endtask

  task automatic test_segment_select();
    write_reg(ppac_pkg::REG_BREAKPOINT, 64'h7FFF_1000_0100_0010);
    write_reg(ppac_pkg::REG_SLOPE, 64'h3000_0800_1800_1000);
    write_reg(ppac_pkg::REG_OFFSET, 64'hFFF0_0040_FF00_0100);
    write_reg(ppac_pkg::REG_SEG_COUNT, ppac_pkg::TAB_W'(4));
    send_motion(mk_motion(16, 0, 1'b0));
    send_motion(mk_motion(17, 0, 1'b0));
    send_motion(mk_motion(0, -256, 1'b0));
    send_motion(mk_motion(16'h0AAA, -16'sh0555, 1'b0));
    send_motion(mk_motion(-32768, -32768, 1'b0));
    send_motion(mk_motion(0, 0, 1'b1));
    drain_results();
    // zero behaves as one segment, anything past SEGMENTS as all of them
    write_reg(ppac_pkg::REG_SEG_COUNT, ppac_pkg::TAB_W'(0));
    send_motion(mk_motion(32767, 0, 1'b0));
    drain_results();
    write_reg(ppac_pkg::REG_SEG_COUNT, ppac_pkg::TAB_W'(7));
    send_motion(mk_motion(-32768, 5, 1'b0));
    drain_results();
  endtask

  task automatic test_negative_gain();
    write_reg(ppac_pkg::REG_SEG_COUNT, ppac_pkg::TAB_W'(1));
    write_reg(ppac_pkg::REG_SLOPE, 64'h0);
    write_reg(ppac_pkg::REG_OFFSET, 64'h0000_0000_0000_8000);
    send_motion(mk_motion(1, 0, 1'b0));
    send_motion(mk_motion(-3, 7, 1'b0));
    send_motion(mk_motion(32767, 32767, 1'b0));
    drain_results();
    write_reg(ppac_pkg::REG_OFFSET, 64'h0000_0000_0000_7FFF);
    send_motion(mk_motion(1, -1, 1'b0));
    drain_results();
  endtask

  task automatic test_touchpad_carry();
    write_reg(ppac_pkg::REG_SLOPE, 64'h0800_0800_0800_0800);
    write_reg(ppac_pkg::REG_OFFSET, 64'h0);
    write_reg(ppac_pkg::REG_SEG_COUNT, ppac_pkg::TAB_W'(2));
    write_reg(ppac_pkg::REG_CARRY_MODE, ppac_pkg::TAB_W'(1));
    send_motion(mk_motion(1, -1, 1'b0));
    send_motion(mk_motion(3, -3, 1'b0));
    send_motion(mk_motion(5, 7, 1'b0));
    send_motion(mk_motion(1, 1, 1'b1));
    send_motion(mk_motion(-32768, 32767, 1'b0));
    drain_results();
    // carries must survive a trip through mouse mode
    write_reg(ppac_pkg::REG_CARRY_MODE, ppac_pkg::TAB_W'(0));
    send_motion(mk_motion(9, -9, 1'b0));
    drain_results();
    write_reg(ppac_pkg::REG_CARRY_MODE, ppac_pkg::TAB_W'(1));
    send_motion(mk_motion(1, -1, 1'b0));
    drain_results();
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    rsp_holdoff = 400;
    repeat (12) send_motion(rand_motion());
    drain_results();
    sender_gaps = 1'b1;
  endtask

  task automatic load_random_curve(int ph);
    logic [ppac_pkg::TAB_W-1:0] bp, sl, off;
    int brk;
    brk = 0;
    bp = '0;
    sl = '0;
    off = '0;
    case (ph % 6)
      0: ;
      1: begin
        bp = '1;
        sl = '1;
        off = '1;
      end
      default: begin
        for (int i = 0; i < ppac_pkg::SEGMENTS; i++) begin
          brk = brk + $urandom_range(0, 16'h2000);
          bp[16*i +: 16] = (ph % 5 == 4) ? 16'($urandom) : 16'(brk);
          sl[16*i +: 16] = 16'($urandom_range(0, 16'h3000));
          off[16*i +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                          : 16'(int'($urandom_range(0, 2048)) - 1024);
        end
      end
    endcase
    write_reg(ppac_pkg::REG_BREAKPOINT, bp);
    write_reg(ppac_pkg::REG_SLOPE, sl);
    write_reg(ppac_pkg::REG_OFFSET, off);
    write_reg(ppac_pkg::REG_SEG_COUNT, ppac_pkg::TAB_W'(ph % 8));
    write_reg(ppac_pkg::REG_CARRY_MODE, ppac_pkg::TAB_W'($urandom_range(0, 2) != 0));
  endtask

  task automatic test_random_traffic(int n_items);
    for (int ph = 0; ph * 100 < n_items; ph++) begin
      load_random_curve(ph);
      sender_gaps = (ph % 4 != 3);
      rcv_stall_en = (ph % 4 != 2);
      repeat (100) send_motion(rand_motion());
      drain_results();
    end
  endtask

  // receiver: alternating ready/stall runs of random length, always ready with stalls off, or a long hold-off
  always @(negedge clk) begin
    if (rsp_holdoff > 0) begin
      rsp_holdoff--;
      rsp_ready <= 1'b0;
    end else if (!rcv_stall_en) begin
      rsp_ready <= 1'b1;
    end else begin
      if (rcv_run == 0) begin
        rcv_on = !rcv_on;
        rcv_run = rcv_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end
      rcv_run--;
      rsp_ready <= rcv_on;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no report pending");
        mismatch_cnt++;
      end else begin
        want_rsp = pending_results.pop_front();
        if (rsp.out_dx !== want_rsp.out_dx) begin
          $error("out_dx: expected %0d, actual %0d",
                 $signed(want_rsp.out_dx), $signed(rsp.out_dx));
          mismatch_cnt++;
        end
        if (rsp.out_dy !== want_rsp.out_dy) begin
          $error("out_dy: expected %0d, actual %0d",
                 $signed(want_rsp.out_dy), $signed(rsp.out_dy));
          mismatch_cnt++;
        end
        if (rsp.segment_used !== want_rsp.segment_used) begin
          $error("segment_used: expected %0d, actual %0d",
                 want_rsp.segment_used, rsp.segment_used);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ppac_pkg::REG_BREAKPOINT;
    cfg_data = '0;
    bp_tab = ppac_pkg::BP_RESET;
    slope_tab = ppac_pkg::SLOPE_RESET;
    off_tab = ppac_pkg::OFFSET_RESET;
    seg_count = ppac_pkg::SEG_COUNT_RESET;
    touch_mode = 1'b0;
    carry_q[0] = '0;
    carry_q[1] = '0;
    mismatch_cnt = 0;
    burst_left = 0;
    sender_gaps = 1'b1;
    rcv_stall_en = 1'b1;
    rcv_on = 1'b0;
    rcv_run = 0;
    rsp_holdoff = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_curve();
    test_segment_select();
    test_negative_gain();
    test_touchpad_carry();
    test_backpressure();
    test_random_traffic(1500);

    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
